// ===== hw/rtl/rscs_pkg.sv =====
// shared types and constants for the ranked spring corner smear block
package rscs_pkg;

    localparam int POS_W  = 22;
    localparam int PX_W   = 13;
    localparam int DT_W   = 10;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DIST_W = 47;
    localparam int LIM_W  = 40;

    localparam logic [DT_W-1:0] DT_MAX = 10'd768;
    localparam logic [18:0] RECIP3 = 19'd349526;

    localparam logic [15:0] RST_STIFFNESS  = 16'd18350;
    localparam logic [15:0] RST_TAIL_SLACK = 16'd27525;
    localparam logic [15:0] RST_SETTLE     = 16'd154;
    localparam logic [7:0]  RST_CELL_W     = 8'd9;
    localparam logic [7:0]  RST_CELL_H     = 8'd20;

    typedef enum logic [2:0] {
        REG_STIFFNESS  = 3'd0,
        REG_TAIL_SLACK = 3'd1,
        REG_SETTLE     = 3'd2,
        REG_CELL_W     = 3'd3,
        REG_CELL_H     = 3'd4
    } t_reg_idx;

    typedef enum logic [4:0] {
        OP_NONE, OP_LATCH, OP_TGT, OP_SNAP, OP_LIM, OP_LIMW, OP_DX, OP_DY, OP_DSUM,
        OP_SORT, OP_Q, OP_K, OP_KT, OP_SQI, OP_SQS, OP_SQE, OP_ACCM, OP_B8, OP_B9,
        OP_B9W, OP_ACCW, OP_A, OP_AZ, OP_MX, OP_MXW, OP_MYW, OP_OUT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] idx;
        logic [1:0] rank;
        logic [2:0] step;
    } t_cmd;

    typedef struct packed {
        logic            ptr_in;
        logic            far;
        logic            k_zero;
        logic            far_any;
        logic [DT_W-1:0] dt;
    } t_status;

    typedef struct packed {
        logic [15:0] stiffness;
        logic [15:0] tail_slack;
        logic [15:0] settle;
        logic [7:0]  cell_w;
        logic [7:0]  cell_h;
    } t_cfg;

endpackage

// ===== hw/rtl/rscs_if.sv =====
// input and result channel interfaces
interface rscs_in_if;
    import rscs_pkg::*;
    logic                   valid;
    logic                   ready;
    logic signed [PX_W-1:0] pointer_x;
    logic signed [PX_W-1:0] pointer_y;
    logic                   pointer_inside;
    logic [DT_W-1:0]        elapsed_frames;
    modport source (output valid, pointer_x, pointer_y, pointer_inside, elapsed_frames,
                    input ready);
    modport sink (input valid, pointer_x, pointer_y, pointer_inside, elapsed_frames,
                  output ready);
endinterface

interface rscs_out_if;
    import rscs_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] corner0_x;
    logic signed [POS_W-1:0] corner0_y;
    logic signed [POS_W-1:0] corner1_x;
    logic signed [POS_W-1:0] corner1_y;
    logic signed [POS_W-1:0] corner2_x;
    logic signed [POS_W-1:0] corner2_y;
    logic signed [POS_W-1:0] corner3_x;
    logic signed [POS_W-1:0] corner3_y;
    logic                    moving;
    logic                    began;
    logic                    came_to_rest;
    modport source (output valid, corner0_x, corner0_y, corner1_x, corner1_y, corner2_x,
                    corner2_y, corner3_x, corner3_y, moving, began, came_to_rest,
                    input ready);
    modport sink (input valid, corner0_x, corner0_y, corner1_x, corner1_y, corner2_x,
                  corner2_y, corner3_x, corner3_y, moving, began, came_to_rest,
                  output ready);
endinterface

// ===== hw/rtl/rscs_regs.sv =====
// configuration register file behind the apb port
module rscs_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rscs_pkg::ADDR_W-1:0]   paddr,
    input  logic [rscs_pkg::DATA_W-1:0]   pwdata,
    output logic [rscs_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output rscs_pkg::t_cfg                o_cfg
);
    import rscs_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx sel;

    assign sel    = t_reg_idx'(paddr[4:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stiffness  <= RST_STIFFNESS;
            r_cfg.tail_slack <= RST_TAIL_SLACK;
            r_cfg.settle     <= RST_SETTLE;
            r_cfg.cell_w     <= RST_CELL_W;
            r_cfg.cell_h     <= RST_CELL_H;
        end else if (psel && penable && pwrite) begin
            unique case (sel)
                REG_STIFFNESS:  r_cfg.stiffness  <= pwdata[15:0];
                REG_TAIL_SLACK: r_cfg.tail_slack <= pwdata[15:0];
                REG_SETTLE:     r_cfg.settle     <= pwdata[15:0];
                REG_CELL_W:     r_cfg.cell_w     <= pwdata[7:0];
                REG_CELL_H:     r_cfg.cell_h     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            REG_STIFFNESS:  prdata = {16'b0, r_cfg.stiffness};
            REG_TAIL_SLACK: prdata = {16'b0, r_cfg.tail_slack};
            REG_SETTLE:     prdata = {16'b0, r_cfg.settle};
            REG_CELL_W:     prdata = {24'b0, r_cfg.cell_w};
            REG_CELL_H:     prdata = {24'b0, r_cfg.cell_h};
            default:        prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/rscs_dp.sv =====
// datapath: corner state, shared multiplier, square root, sort and spring step
module rscs_dp #(
    parameter int FRAC_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rscs_pkg::t_cmd                    i_cmd,
    input  rscs_pkg::t_cfg                    i_cfg,
    input  logic signed [rscs_pkg::PX_W-1:0]  i_px,
    input  logic signed [rscs_pkg::PX_W-1:0]  i_py,
    input  logic                              i_inside,
    input  logic [rscs_pkg::DT_W-1:0]         i_dt,
    output rscs_pkg::t_status                 o_status,
    output logic signed [rscs_pkg::POS_W-1:0] o_cx [4],
    output logic signed [rscs_pkg::POS_W-1:0] o_cy [4]
);
    import rscs_pkg::*;

    localparam int GW     = (15 + FRAC_BITS > POS_W + 1) ? 15 + FRAC_BITS : POS_W + 1;
    localparam int SET_UP = (FRAC_BITS >= 8) ? FRAC_BITS - 8 : 0;
    localparam int SET_DN = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;

    logic signed [PX_W-1:0]   r_px, r_py, r_tx, r_ty;
    logic                     r_inside;
    logic [DT_W-1:0]          r_dt;
    logic signed [POS_W-1:0]  r_pos_x [4];
    logic signed [POS_W-1:0]  r_pos_y [4];
    logic signed [POS_W-1:0]  r_out_x [4];
    logic signed [POS_W-1:0]  r_out_y [4];
    logic signed [PROD_W-1:0] r_prod;
    logic [DIST_W-1:0]        r_sd [4];
    logic [1:0]               r_ord [4];
    logic [LIM_W-1:0]         r_lim;
    logic                     r_far_any;
    logic [15:0]              r_k;
    logic [31:0]              r_base, r_root;
    logic [32:0]              r_acc;
    logic [63:0]              r_v, r_res, r_bit;
    logic [16:0]              r_a;

    function automatic logic signed [POS_W-1:0] to_pos(input logic signed [13:0] v);
        logic signed [GW-1:0] s;
        logic signed [POS_W-1:0] r;
        s = GW'(v) <<< FRAC_BITS;
        if ((s[GW-1:POS_W-1] == '0) || (s[GW-1:POS_W-1] == '1)) begin
            r = s[POS_W-1:0];
        end else if (s[GW-1]) begin
            r = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(POS_W-1){1'b1}}};
        end
        return r;
    endfunction

    logic signed [13:0]       tx0, ty0, tx1, ty1;
    logic signed [POS_W-1:0]  goal_x [4];
    logic signed [POS_W-1:0]  goal_y [4];
    logic                     is_move;
    logic [1:0]               csel;
    logic signed [POS_W:0]    dx, dy;
    logic signed [13:0]       ex, ey;
    logic [19:0]              lim_lin;
    logic [17:0]              ts_r;
    logic [16:0]              omq, omk;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic                     is_mul;
    logic signed [PROD_W-1:0] rnd;
    logic signed [23:0]       step;
    logic [63:0]              trial;
    logic [DIST_W-1:0]        dsum;
    logic [33:0]              afrac;

    assign tx0 = 14'(r_tx);
    assign ty0 = 14'(r_ty);
    assign tx1 = tx0 + $signed({6'b0, i_cfg.cell_w});
    assign ty1 = ty0 + $signed({6'b0, i_cfg.cell_h});

    always_comb begin
        goal_x[0] = to_pos(tx0);
        goal_x[1] = to_pos(tx1);
        goal_x[2] = to_pos(tx1);
        goal_x[3] = to_pos(tx0);
        goal_y[0] = to_pos(ty0);
        goal_y[1] = to_pos(ty0);
        goal_y[2] = to_pos(ty1);
        goal_y[3] = to_pos(ty1);
    end

    assign is_move = (i_cmd.op == OP_MX) || (i_cmd.op == OP_MXW) || (i_cmd.op == OP_MYW);
    assign csel    = is_move ? r_ord[i_cmd.rank] : i_cmd.idx;
    assign dx      = (POS_W+1)'(goal_x[csel]) - (POS_W+1)'(r_pos_x[csel]);
    assign dy      = (POS_W+1)'(goal_y[csel]) - (POS_W+1)'(r_pos_y[csel]);

    // pointer move of more than one pixel
    assign ex = 14'(r_px) - 14'(r_tx);
    assign ey = 14'(r_py) - 14'(r_ty);

    assign lim_lin = (20'(i_cfg.settle) << SET_UP) >> SET_DN;
    assign ts_r    = ({2'b0, i_cfg.tail_slack} & {18{i_cmd.rank[0]}})
                   + ({1'b0, i_cfg.tail_slack, 1'b0} & {18{i_cmd.rank[1]}});
    assign omq     = 17'd65536 - {1'b0, r_prod[35:20]};
    assign omk     = 17'd65536 - {1'b0, r_prod[31:16]};

    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        is_mul = 1'b1;
        case (i_cmd.op)
            OP_LIM:  begin mul_a = MUL_W'(lim_lin);           mul_b = MUL_W'(lim_lin);  end
            OP_DX:   begin mul_a = MUL_W'(dx);                mul_b = MUL_W'(dx);       end
            OP_DY:   begin mul_a = MUL_W'(dy);                mul_b = MUL_W'(dy);       end
            OP_Q:    begin mul_a = MUL_W'(ts_r);              mul_b = MUL_W'(RECIP3);   end
            OP_K:    begin mul_a = MUL_W'(i_cfg.stiffness);   mul_b = MUL_W'(omq);      end
            OP_ACCM: begin mul_a = MUL_W'(r_acc);             mul_b = MUL_W'(r_root);   end
            OP_B8:   begin mul_a = MUL_W'(r_acc);             mul_b = MUL_W'(r_base);   end
            OP_B9:   begin mul_a = MUL_W'(r_base);            mul_b = MUL_W'(r_base);   end
            OP_MX:   begin mul_a = MUL_W'(dx);                mul_b = MUL_W'(r_a);      end
            OP_MXW:  begin mul_a = MUL_W'(dy);                mul_b = MUL_W'(r_a);      end
            default: is_mul = 1'b0;
        endcase
    end

    assign rnd   = r_prod + PROD_W'(32768);
    assign step  = rnd[39:16];
    assign trial = r_res + r_bit;
    assign dsum  = r_sd[i_cmd.idx] + r_prod[DIST_W-1:0];
    assign afrac = 34'h1_0000_0000 - {1'b0, r_acc} + 34'd32768;

    // architectural state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx <= '0;
            r_ty <= '0;
            for (int i = 0; i < 4; i++) begin
                r_pos_x[i] <= '0;
                r_pos_y[i] <= '0;
            end
        end else begin
            case (i_cmd.op)
                OP_TGT: begin
                    r_tx <= r_px;
                    r_ty <= r_py;
                end
                OP_SNAP: begin
                    for (int i = 0; i < 4; i++) begin
                        r_pos_x[i] <= goal_x[i];
                        r_pos_y[i] <= goal_y[i];
                    end
                end
                OP_MXW: r_pos_x[csel] <= r_pos_x[csel] + step[POS_W-1:0];
                OP_MYW: r_pos_y[csel] <= r_pos_y[csel] + step[POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_mul) begin
            r_prod <= mul_a * mul_b;
        end
        case (i_cmd.op)
            OP_LATCH: begin
                r_px     <= i_px;
                r_py     <= i_py;
                r_inside <= i_inside;
                r_dt     <= (i_dt > DT_MAX) ? DT_MAX : i_dt;
            end
            OP_LIMW: begin
                r_lim     <= r_prod[LIM_W-1:0];
                r_far_any <= 1'b0;
            end
            OP_DY: begin
                r_sd[i_cmd.idx]  <= r_prod[DIST_W-1:0];
                r_ord[i_cmd.idx] <= i_cmd.idx;
            end
            OP_DSUM: begin
                r_sd[i_cmd.idx] <= dsum;
                if (dsum > DIST_W'(r_lim)) begin
                    r_far_any <= 1'b1;
                end
            end
            OP_SORT: begin
                case (i_cmd.step)
                    3'd0: if (r_sd[1] < r_sd[0]) begin
                        r_sd[0] <= r_sd[1]; r_sd[1] <= r_sd[0];
                        r_ord[0] <= r_ord[1]; r_ord[1] <= r_ord[0];
                    end
                    3'd1: if (r_sd[2] < r_sd[0]) begin
                        r_sd[0] <= r_sd[2]; r_sd[2] <= r_sd[0];
                        r_ord[0] <= r_ord[2]; r_ord[2] <= r_ord[0];
                    end
                    3'd2: if (r_sd[3] < r_sd[0]) begin
                        r_sd[0] <= r_sd[3]; r_sd[3] <= r_sd[0];
                        r_ord[0] <= r_ord[3]; r_ord[3] <= r_ord[0];
                    end
                    3'd3: if (r_sd[2] < r_sd[1]) begin
                        r_sd[1] <= r_sd[2]; r_sd[2] <= r_sd[1];
                        r_ord[1] <= r_ord[2]; r_ord[2] <= r_ord[1];
                    end
                    3'd4: if (r_sd[3] < r_sd[1]) begin
                        r_sd[1] <= r_sd[3]; r_sd[3] <= r_sd[1];
                        r_ord[1] <= r_ord[3]; r_ord[3] <= r_ord[1];
                    end
                    3'd5: if (r_sd[3] < r_sd[2]) begin
                        r_sd[2] <= r_sd[3]; r_sd[3] <= r_sd[2];
                        r_ord[2] <= r_ord[3]; r_ord[3] <= r_ord[2];
                    end
                    default: ;
                endcase
            end
            OP_KT: begin
                r_k    <= r_prod[31:16];
                r_base <= {omk[15:0], 16'b0};
                r_root <= {omk[15:0], 16'b0};
                r_acc  <= 33'h1_0000_0000;
            end
            OP_SQI: begin
                r_v   <= {r_root, 32'b0};
                r_res <= '0;
                r_bit <= 64'h4000_0000_0000_0000;
            end
            OP_SQS: begin
                if (r_v >= trial) begin
                    r_v   <= r_v - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_SQE:  r_root <= r_res[31:0];
            OP_B9W:  r_root <= r_prod[63:32];
            OP_ACCW: r_acc  <= r_prod[64:32];
            OP_A:    r_a    <= afrac[32:16];
            OP_AZ:   r_a    <= '0;
            OP_OUT: begin
                for (int i = 0; i < 4; i++) begin
                    r_out_x[i] <= r_pos_x[i];
                    r_out_y[i] <= r_pos_y[i];
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_status.ptr_in  = r_inside;
        o_status.far     = !(((ex == 14'sd0) && ((ey == 14'sd0) || (ey == 14'sd1) ||
                                                 (ey == -14'sd1))) ||
                             ((ey == 14'sd0) && ((ex == 14'sd1) || (ex == -14'sd1))));
        o_status.k_zero  = (r_k == 16'd0);
        o_status.far_any = r_far_any;
        o_status.dt      = r_dt;
    end

    assign o_cx = r_out_x;
    assign o_cy = r_out_y;

endmodule

// ===== hw/rtl/rscs_ctrl.sv =====
// controller: sequences one tick through target update, ranking and spring step
module rscs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  rscs_pkg::t_status i_status,
    output rscs_pkg::t_cmd    o_cmd,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output logic              o_moving,
    output logic              o_began,
    output logic              o_rested
);
    import rscs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_TGT, S_SNAP1, S_LIM, S_LIMW, S_DX, S_DY, S_DSUM, S_SORT, S_Q, S_K,
        S_KT, S_ZCHK, S_SQI, S_SQS, S_SQE, S_ACCM, S_ACCW, S_P8, S_P9, S_B9W, S_A, S_AZ,
        S_MX, S_MXW, S_MYW, S_SETTLE, S_OUT
    } t_state;

    typedef enum logic [1:0] {PH_ROOT, PH_B8, PH_B9} t_phase;

    t_state     r_state;
    t_phase     r_phase;
    logic [1:0] r_idx, r_rank;
    logic [2:0] r_n;
    logic [4:0] r_it;
    logic       r_motion, r_seen, r_began, r_rested;
    logic       r_out_valid, r_out_moving, r_out_began, r_out_rested;
    logic [7:0] dt_lo;
    logic       tgt_move, load_out;

    assign dt_lo    = i_status.dt[7:0];
    assign tgt_move = i_status.ptr_in && (!r_seen || i_status.far);
    assign load_out = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        o_cmd.op   = OP_NONE;
        o_cmd.idx  = r_idx;
        o_cmd.rank = r_rank;
        o_cmd.step = r_n;
        unique case (r_state)
            S_IDLE:   o_cmd.op = i_in_valid ? OP_LATCH : OP_NONE;
            S_TGT:    o_cmd.op = tgt_move ? OP_TGT : OP_NONE;
            S_SNAP1:  o_cmd.op = OP_SNAP;
            S_LIM:    o_cmd.op = OP_LIM;
            S_LIMW:   o_cmd.op = OP_LIMW;
            S_DX:     o_cmd.op = OP_DX;
            S_DY:     o_cmd.op = OP_DY;
            S_DSUM:   o_cmd.op = OP_DSUM;
            S_SORT:   o_cmd.op = OP_SORT;
            S_Q:      o_cmd.op = OP_Q;
            S_K:      o_cmd.op = OP_K;
            S_KT:     o_cmd.op = OP_KT;
            S_ZCHK:   o_cmd.op = OP_NONE;
            S_SQI:    o_cmd.op = OP_SQI;
            S_SQS:    o_cmd.op = OP_SQS;
            S_SQE:    o_cmd.op = OP_SQE;
            S_ACCM:   o_cmd.op = OP_ACCM;
            S_ACCW:   o_cmd.op = OP_ACCW;
            S_P8:     o_cmd.op = i_status.dt[8] ? OP_B8 : OP_NONE;
            S_P9:     o_cmd.op = i_status.dt[9] ? OP_B9 : OP_NONE;
            S_B9W:    o_cmd.op = OP_B9W;
            S_A:      o_cmd.op = OP_A;
            S_AZ:     o_cmd.op = OP_AZ;
            S_MX:     o_cmd.op = OP_MX;
            S_MXW:    o_cmd.op = OP_MXW;
            S_MYW:    o_cmd.op = OP_MYW;
            S_SETTLE: o_cmd.op = i_status.far_any ? OP_NONE : OP_SNAP;
            S_OUT:    o_cmd.op = load_out ? OP_OUT : OP_NONE;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= PH_ROOT;
            r_idx        <= '0;
            r_rank       <= '0;
            r_n          <= '0;
            r_it         <= '0;
            r_motion     <= 1'b0;
            r_seen       <= 1'b0;
            r_began      <= 1'b0;
            r_rested     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_moving <= 1'b0;
            r_out_began  <= 1'b0;
            r_out_rested <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid  <= 1'b1;
                r_out_moving <= r_motion;
                r_out_began  <= r_began;
                r_out_rested <= r_rested;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_began  <= 1'b0;
                    r_rested <= 1'b0;
                    r_state  <= S_TGT;
                end
                S_TGT: begin
                    if (i_status.ptr_in && r_seen) begin
                        if (i_status.far && !r_motion) begin
                            r_motion <= 1'b1;
                            r_began  <= 1'b1;
                        end
                        r_state <= (r_motion || i_status.far) ? S_LIM : S_OUT;
                    end else if (i_status.ptr_in) begin
                        r_seen  <= 1'b1;
                        r_state <= S_SNAP1;
                    end else begin
                        r_state <= r_motion ? S_LIM : S_OUT;
                    end
                end
                S_SNAP1: r_state <= r_motion ? S_LIM : S_OUT;
                S_LIM:   r_state <= S_LIMW;
                S_LIMW: begin
                    r_idx   <= '0;
                    r_state <= S_DX;
                end
                S_DX: r_state <= S_DY;
                S_DY: r_state <= S_DSUM;
                S_DSUM: begin
                    if (r_idx == 2'd3) begin
                        r_n     <= '0;
                        r_state <= S_SORT;
                    end else begin
                        r_state <= S_DX;
                    end
                    r_idx <= r_idx + 2'd1;
                end
                S_SORT: begin
                    if (r_n == 3'd5) begin
                        r_rank  <= '0;
                        r_state <= S_Q;
                    end
                    r_n <= r_n + 3'd1;
                end
                S_Q:  r_state <= S_K;
                S_K:  r_state <= S_KT;
                S_KT: r_state <= S_ZCHK;
                S_ZCHK: begin
                    r_n     <= '0;
                    r_phase <= PH_ROOT;
                    r_state <= (i_status.k_zero || (i_status.dt == '0)) ? S_AZ : S_SQI;
                end
                S_SQI: begin
                    r_it    <= '0;
                    r_state <= S_SQS;
                end
                S_SQS: begin
                    if (r_it == 5'd31) begin
                        r_state <= S_SQE;
                    end
                    r_it <= r_it + 5'd1;
                end
                S_SQE: begin
                    if (dt_lo[~r_n]) begin
                        r_state <= S_ACCM;
                    end else if (r_n == 3'd7) begin
                        r_state <= S_P8;
                    end else begin
                        r_n     <= r_n + 3'd1;
                        r_state <= S_SQI;
                    end
                end
                S_ACCM: r_state <= S_ACCW;
                S_ACCW: begin
                    unique case (r_phase)
                        PH_ROOT: begin
                            if (r_n == 3'd7) begin
                                r_state <= S_P8;
                            end else begin
                                r_n     <= r_n + 3'd1;
                                r_state <= S_SQI;
                            end
                        end
                        PH_B8:   r_state <= S_P9;
                        PH_B9:   r_state <= S_A;
                        default: r_state <= S_A;
                    endcase
                end
                S_P8: begin
                    if (i_status.dt[8]) begin
                        r_phase <= PH_B8;
                        r_state <= S_ACCW;
                    end else begin
                        r_state <= S_P9;
                    end
                end
                S_P9: r_state <= i_status.dt[9] ? S_B9W : S_A;
                S_B9W: begin
                    r_phase <= PH_B9;
                    r_state <= S_ACCM;
                end
                S_A:   r_state <= S_MX;
                S_AZ:  r_state <= S_MX;
                S_MX:  r_state <= S_MXW;
                S_MXW: r_state <= S_MYW;
                S_MYW: begin
                    if (r_rank == 2'd3) begin
                        r_state <= S_SETTLE;
                    end else begin
                        r_state <= S_Q;
                    end
                    r_rank <= r_rank + 2'd1;
                end
                S_SETTLE: begin
                    if (!i_status.far_any) begin
                        r_motion <= 1'b0;
                        r_rested <= 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: if (load_out) begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_moving    = r_out_moving;
    assign o_began     = r_out_began;
    assign o_rested    = r_out_rested;

endmodule

// ===== hw/rtl/ranked_spring_corner_smear.sv =====
// top level of the ranked spring corner smear block
// Each transfer on the input channel yields exactly one result transfer. A tick
// that leaves the corners at rest skips the spring step; the length of a tick in
// motion is set by the 32-step bit-serial square root, run eight times for each
// of the four ranks, and by the shared 34x34 multiplier that forms the pull
// fraction; a rank with zero stiffness or zero elapsed time skips that work.
// One tick is in flight at a time; the finished result waits in the output
// register, so the next tick can be taken while it is still pending.
module ranked_spring_corner_smear #(
    parameter int FRAC_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    rscs_in_if.sink                      i_in,
    rscs_out_if.source                   o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rscs_pkg::ADDR_W-1:0]  paddr,
    input  logic [rscs_pkg::DATA_W-1:0]  pwdata,
    output logic [rscs_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import rscs_pkg::*;

    t_cfg                    cfg;
    t_cmd                    cmd;
    t_status                 status;
    logic signed [POS_W-1:0] cx [4];
    logic signed [POS_W-1:0] cy [4];

    rscs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rscs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_moving    (o_out.moving),
        .o_began     (o_out.began),
        .o_rested    (o_out.came_to_rest)
    );

    rscs_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_cfg    (cfg),
        .i_px     (i_in.pointer_x),
        .i_py     (i_in.pointer_y),
        .i_inside (i_in.pointer_inside),
        .i_dt     (i_in.elapsed_frames),
        .o_status (status),
        .o_cx     (cx),
        .o_cy     (cy)
    );

    assign o_out.corner0_x = cx[0];
    assign o_out.corner0_y = cy[0];
    assign o_out.corner1_x = cx[1];
    assign o_out.corner1_y = cy[1];
    assign o_out.corner2_x = cx[2];
    assign o_out.corner2_y = cy[2];
    assign o_out.corner3_x = cx[3];
    assign o_out.corner3_y = cy[3];

endmodule

// ===== hw/rtl/rscs_chk.sv =====
// port-level checker for the ranked spring corner smear block, with its bind
module rscs_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_moving,
    input logic i_began,
    input logic i_rested
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    a_rest_not_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_rested |-> !i_moving)
        else $error("settled tick still reports motion");

    a_began_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_began && !i_rested |-> i_moving)
        else $error("started motion not reported as moving");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second tick taken while one is in work");

endmodule

bind ranked_spring_corner_smear rscs_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_moving    (o_out.moving),
    .i_began     (o_out.began),
    .i_rested    (o_out.came_to_rest)
);
